>>> hdl/assert_macros.svh
// Assertion macros shared by the RGB-to-gray Gaussian window RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is switched off while reset is asserted.
`define RGW_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that must hold at every edge, reset included.
`define RGW_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hdl/rgw_pkg.sv
// Shared types, constants and arithmetic helpers for the gray 5x5 Gaussian core.
// No dependencies; imported by the interfaces and all modules.
package rgw_pkg;

  localparam int WIN_DIM  = 5;
  localparam int WIN_SIZE = WIN_DIM * WIN_DIM;
  localparam int CNT_W    = 5;

  localparam int PIX_W  = 8;
  localparam int ACC_W  = 18;   // 299r+587g+114b+500 <= 255500
  localparam int ROW_W  = 15;   // heaviest row: 107*255
  localparam int SUM_W  = 17;   // 273*255
  localparam int WGT_W  = 6;

  localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(273 * 255);

  // floor(x/1000) = (x*268436) >> 28, exact for x < 493447
  localparam int GRAY_SHIFT  = 28;
  localparam int GRAY_PROD_W = 37;
  localparam logic [GRAY_PROD_W-1:0] GRAY_RECIP = GRAY_PROD_W'(268436);

  // floor(x/273) = (x*245823) >> 26, exact for x < 82342
  localparam int KDIV_SHIFT  = 26;
  localparam int KDIV_PROD_W = 35;
  localparam logic [KDIV_PROD_W-1:0] KDIV_RECIP = KDIV_PROD_W'(245823);

  localparam logic [ACC_W-1:0] LUMA_R   = ACC_W'(299);
  localparam logic [ACC_W-1:0] LUMA_G   = ACC_W'(587);
  localparam logic [ACC_W-1:0] LUMA_B   = ACC_W'(114);
  localparam logic [ACC_W-1:0] LUMA_RND = ACC_W'(500);

  localparam logic [WGT_W-1:0] KERNEL [WIN_SIZE] = '{
    6'd1,  6'd4,  6'd7,  6'd4,  6'd1,
    6'd4,  6'd16, 6'd26, 6'd16, 6'd4,
    6'd7,  6'd26, 6'd41, 6'd26, 6'd7,
    6'd4,  6'd16, 6'd26, 6'd16, 6'd4,
    6'd1,  6'd4,  6'd7,  6'd4,  6'd1
  };

  typedef logic [PIX_W-1:0]                gray_t;
  typedef gray_t [WIN_SIZE-1:0]            win_t;
  typedef logic [WIN_DIM-1:0][ROW_W-1:0]   rows_t;

  typedef struct packed {
    logic we;       // a pixel is written into the window this cycle
    logic reload;   // reload flag that travels with that pixel
  } win_ctrl_t;

  function automatic logic [ACC_W-1:0] luma_acc(input logic [PIX_W-1:0] r,
                                                input logic [PIX_W-1:0] g,
                                                input logic [PIX_W-1:0] b);
    return LUMA_R * ACC_W'(r) + LUMA_G * ACC_W'(g) + LUMA_B * ACC_W'(b) + LUMA_RND;
  endfunction

  function automatic gray_t gray_from_acc(input logic [ACC_W-1:0] acc);
    logic [GRAY_PROD_W-1:0] prod;
    prod = GRAY_PROD_W'(acc) * GRAY_RECIP;
    return prod[GRAY_SHIFT +: PIX_W];
  endfunction

  function automatic gray_t kernel_div(input logic [SUM_W-1:0] sum);
    logic [KDIV_PROD_W-1:0] prod;
    prod = KDIV_PROD_W'(sum) * KDIV_RECIP;
    return prod[KDIV_SHIFT +: PIX_W];
  endfunction

endpackage

>>> hdl/rgw_pix_if.sv
// Input pixel channel: valid/ready plus RGB components and the reload flag.
// Depends on rgw_pkg.
interface rgw_pix_if;
  import rgw_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] blue;
  logic             reload;

  modport source (output valid, output red, output green, output blue,
                  output reload, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input reload, output ready);
endinterface

>>> hdl/rgw_res_if.sv
// Result channel: valid/ready plus the filtered gray value.
// Depends on rgw_pkg.
interface rgw_res_if;
  import rgw_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

>>> hdl/rgw_window.sv
// 5x5 gray window store with full-load and column-shift fill modes.
// Depends on rgw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rgw_window (
  input  logic               clk,
  input  logic               rst_n,
  input  rgw_pkg::win_ctrl_t ctrl,
  input  rgw_pkg::gray_t     gray,
  output rgw_pkg::win_t      win,
  output logic               complete
);
  import rgw_pkg::*;

  win_t             win_r, win_nxt, shifted;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             mode_r, mode_nxt;
  logic             first, mode_eff, do_shift;

  assign first    = (count_r == '0);
  assign mode_eff = first ? ctrl.reload : mode_r;
  assign do_shift = ctrl.we && first && !ctrl.reload;
  assign complete = ctrl.we && (mode_eff ? (count_r == CNT_W'(WIN_SIZE - 1))
                                         : (count_r == CNT_W'(WIN_DIM - 1)));

  always_comb begin
    for (int v = 0; v < WIN_DIM; v++) begin
      for (int u = 0; u < WIN_DIM - 1; u++) begin
        shifted[v*WIN_DIM + u] = win_r[v*WIN_DIM + u + 1];
      end
      shifted[v*WIN_DIM + WIN_DIM - 1] = win_r[v*WIN_DIM + WIN_DIM - 1];
    end
  end

  always_comb begin
    for (int v = 0; v < WIN_DIM; v++) begin
      for (int u = 0; u < WIN_DIM; u++) begin
        if (ctrl.we && (mode_eff ? (count_r == CNT_W'(v*WIN_DIM + u))
                                 : (u == WIN_DIM - 1 && count_r == CNT_W'(v)))) begin
          win_nxt[v*WIN_DIM + u] = gray;
        end else if (do_shift) begin
          win_nxt[v*WIN_DIM + u] = shifted[v*WIN_DIM + u];
        end else begin
          win_nxt[v*WIN_DIM + u] = win_r[v*WIN_DIM + u];
        end
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    mode_nxt  = mode_r;
    if (ctrl.we) begin
      mode_nxt  = mode_eff;
      count_nxt = complete ? '0 : count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= '0;
      count_r <= '0;
      mode_r  <= 1'b0;
    end else begin
      win_r   <= win_nxt;
      count_r <= count_nxt;
      mode_r  <= mode_nxt;
    end
  end

  assign win = win_r;

  `RGW_ASSERT_ALWAYS(a_count_range, clk, !rst_n || (count_r < CNT_W'(WIN_SIZE)), "pixel count out of range")
  `RGW_ASSERT(a_complete_wraps, clk, rst_n, complete |=> (count_r == '0), "count did not wrap")
  `RGW_ASSERT(a_mode_held, clk, rst_n, (count_r != '0) |=> $stable(mode_r), "mode changed mid-window")

endmodule

>>> hdl/rgw_kernel.sv
// Per-row Gaussian weighted sums of the 5x5 gray window (constant weights).
// Depends on rgw_pkg.
module rgw_kernel (
  input  rgw_pkg::win_t  win,
  output rgw_pkg::rows_t rows
);
  import rgw_pkg::*;

  always_comb begin
    for (int v = 0; v < WIN_DIM; v++) begin
      rows[v] = '0;
      for (int u = 0; u < WIN_DIM; u++) begin
        rows[v] = rows[v] + ROW_W'(win[v*WIN_DIM + u]) * ROW_W'(KERNEL[v*WIN_DIM + u]);
      end
    end
  end

endmodule

>>> hdl/rgb_gray_gaussian_5x5_window_core.sv
// RGB-to-gray 5x5 Gaussian window filter, top level.
// Depends on rgw_pkg, rgw_pix_if, rgw_res_if, rgw_window, rgw_kernel, assert_macros.svh.
//
// Each accepted pixel is turned into gray, (299r+587g+114b+500)/1000, and
// written into a 5x5 window that reset clears to zero. The reload flag of a
// window's first pixel picks the fill mode: 1 loads 25 pixels in row-major
// order, 0 shifts every row one column left and loads 5 pixels top to bottom
// into the right column. When a window completes, one result is emitted:
// floor(sum(gray*K)/273) with the 1-4-7-4-1 / 4-16-26-16-4 / 7-26-41-26-7
// kernel. Pixels that do not complete a window produce no result. Throughput
// is one pixel per cycle while no stage stalls. The pipeline is: luma
// accumulate register, gray/window update, row sums, total sum, and the
// divide-by-273 output register, from which a result leaves. Each stage
// holds its item under backpressure; while a result waits at the output,
// pixels are still taken until three more windows have completed (held in
// the total, row-sum and window stages) and one further pixel waits in the
// luma register.

`include "assert_macros.svh"

module rgb_gray_gaussian_5x5_window_core (
  input  logic clk,
  input  logic rst_n,
  rgw_pix_if.sink   in_pix,
  rgw_res_if.source out_res
);
  import rgw_pkg::*;

  // stage 1: luma accumulator of the accepted pixel
  logic             s1_v_r;
  logic [ACC_W-1:0] acc_r;
  logic             reload_r;
  // stage 2: window holds a completed set awaiting summation
  logic             c2_v_r;
  // stage 3: row sums; stage 4: total
  logic             s3_v_r;
  rows_t            rows_r;
  logic             s4_v_r;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  // output register
  logic             out_v_r;
  gray_t            filtered_r;

  logic      ready_o, ready4, ready3, free2, ready1;
  win_ctrl_t ctrl;
  gray_t     gray;
  win_t      win;
  rows_t     rows;
  logic      complete;

  // Each stage may take a new item when it is empty or its item moves on.
  assign ready_o = !out_v_r || out_res.ready;
  assign ready4  = !s4_v_r  || ready_o;
  assign ready3  = !s3_v_r  || ready4;
  assign free2   = !c2_v_r  || ready3;   // window may be rewritten
  assign ready1  = !s1_v_r  || free2;

  assign in_pix.ready = ready1;

  assign gray        = gray_from_acc(acc_r);
  assign ctrl.we     = s1_v_r && free2;
  assign ctrl.reload = reload_r;

  rgw_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .gray     (gray),
    .win      (win),
    .complete (complete)
  );

  // Reads the window while it still holds the completed set; the window may
  // be overwritten on the same edge that captures these sums.
  rgw_kernel u_kernel (
    .win  (win),
    .rows (rows)
  );

  always_comb begin
    sum_nxt = '0;
    for (int v = 0; v < WIN_DIM; v++) begin
      sum_nxt = sum_nxt + SUM_W'(rows_r[v]);
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      c2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (ready1)  s1_v_r  <= in_pix.valid;
      if (free2)   c2_v_r  <= s1_v_r && complete;
      if (ready3)  s3_v_r  <= c2_v_r;
      if (ready4)  s4_v_r  <= s3_v_r;
      if (ready_o) out_v_r <= s4_v_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ready1) begin
      acc_r    <= luma_acc(in_pix.red, in_pix.green, in_pix.blue);
      reload_r <= in_pix.reload;
    end
    if (ready3)  rows_r     <= rows;
    if (ready4)  sum_r      <= sum_nxt;
    if (ready_o) filtered_r <= kernel_div(sum_r);
  end

  assign out_res.valid    = out_v_r;
  assign out_res.filtered = filtered_r;

  `RGW_ASSERT(a_sum_bound, clk, rst_n, s4_v_r |-> (sum_r <= SUM_MAX), "weighted sum too large")
  `RGW_ASSERT(a_rows_hold, clk, rst_n, (s3_v_r && !ready4) |=> (s3_v_r && $stable(rows_r)), "row sums lost under stall")
  `RGW_ASSERT(a_complete_on_write, clk, rst_n, complete |-> (ctrl.we && s1_v_r), "window completed without a pixel")

endmodule

>>> tb/rgb_gray_gaussian_5x5_window_core_tb.sv
// Testbench for rgb_gray_gaussian_5x5_window_core: a directed pixel table,
// then random traffic, each result checked against a local window predictor.
// Depends on rgw_pkg, rgw_pix_if, rgw_res_if and the core RTL.
module rgb_gray_gaussian_5x5_window_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rgw_pkg::*;

  localparam int N_RANDOM   = 1070;
  localparam int IDLE_LIMIT = 2000;  // cycles with no transfer on either side
  localparam int DRAIN_WAIT = 20;    // pipeline is five deep

  // Gaussian weights, row-major, sum 273
  localparam int unsigned GAUSS_W [25] = '{
    1,  4,  7,  4, 1,
    4, 16, 26, 16, 4,
    7, 26, 41, 26, 7,
    4, 16, 26, 16, 4,
    1,  4,  7,  4, 1
  };

  // One directed pixel. With typed set, filt is the value read off by hand
  // and replaces the predicted one for that row.
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       reload;
    logic       typed;
    logic [7:0] filt;
  } pix_row_t;

  localparam int N_DIRECTED = 30;
  localparam pix_row_t PIXEL_TABLE [N_DIRECTED] = '{
    // shift into the cleared window: white lands in the right column only,
    // reload is ignored after the first pixel; 255*17/273 -> 15
    '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 8'd0},
    '{8'd255, 8'd255, 8'd255, 1'b1, 1'b0, 8'd0},
    '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 8'd0},
    '{8'd255, 8'd255, 8'd255, 1'b1, 1'b0, 8'd0},
    '{8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 8'd15},
    // full load of pure primaries, white and black; reload toggles mid-window
    '{8'd255, 8'd0,   8'd0,   1'b1, 1'b0, 8'd0},
    '{8'd0,   8'd255, 8'd0,   1'b0, 1'b0, 8'd0},
    '{8'd0,   8'd0,   8'd255, 1'b1, 1'b0, 8'd0},
    '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 8'd0},
    '{8'd0,   8'd0,   8'd0,   1'b1, 1'b0, 8'd0},
    '{8'd255, 8'd255, 8'd0,   1'b0, 1'b0, 8'd0},
    '{8'd0,   8'd255, 8'd255, 1'b0, 1'b0, 8'd0},
    '{8'd255, 8'd0,   8'd255, 1'b1, 1'b0, 8'd0},
    '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 8'd0},
    '{8'd255, 8'd255, 8'd255, 1'b1, 1'b0, 8'd0},
    '{8'd1,   8'd1,   8'd1,   1'b0, 1'b0, 8'd0},
    '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 8'd0},
    '{8'd255, 8'd255, 8'd255, 1'b1, 1'b0, 8'd0},
    '{8'd254, 8'd254, 8'd254, 1'b0, 1'b0, 8'd0},
    '{8'd128, 8'd64,  8'd32,  1'b1, 1'b0, 8'd0},
    '{8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 8'd0},
    '{8'd255, 8'd255, 8'd255, 1'b1, 1'b0, 8'd0},
    '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 8'd0},
    '{8'd170, 8'd85,  8'd170, 1'b1, 1'b0, 8'd0},
    '{8'd85,  8'd170, 8'd85,  1'b0, 1'b0, 8'd0},
    '{8'd255, 8'd0,   8'd0,   1'b1, 1'b0, 8'd0},
    '{8'd0,   8'd255, 8'd0,   1'b0, 1'b0, 8'd0},
    '{8'd0,   8'd0,   8'd255, 1'b1, 1'b0, 8'd0},
    '{8'd7,   8'd200, 8'd99,  1'b0, 1'b0, 8'd0},
    '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 8'd0}
  };

  logic clk = 1'b0;
  logic rst_n;

  rgw_pix_if pix_bus ();
  rgw_res_if res_bus ();

  rgb_gray_gaussian_5x5_window_core DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix_bus),
    .out_res (res_bus)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor state: its own copy of the gray window and fill progress
  // ---------------------------------------------------------------------
  logic [7:0] gray_win [25];
  logic [4:0] fill_cnt;
  logic       fill_full;   // latched reload of the current window

  logic [7:0] filt_expected [$];
  int         fail_count = 0;
  bit         sink_calm;   // stretch with no receiver stalls

  // luma rounded half up
  function automatic logic [7:0] luma_gray(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
    logic [17:0] acc;
    acc = 18'd299 * r + 18'd587 * g + 18'd114 * b + 18'd500;
    return 8'(acc / 18'd1000);
  endfunction

  function automatic logic [7:0] gauss_of_window();
    logic [16:0] sum;
    sum = '0;
    for (int i = 0; i < 25; i++) sum += 17'(gray_win[i]) * 17'(GAUSS_W[i]);
    return 8'(sum / 17'd273);
  endfunction

  // Advance the window with one accepted pixel; done is set when it completes.
  task automatic gauss_predict(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                               input logic reload, output bit done, output logic [7:0] filt);
    logic [7:0] gray;
    int         needed;
    gray = luma_gray(r, g, b);
    done = 1'b0;
    filt = '0;
    if (fill_cnt == 0) begin
      fill_full = reload;
      // shift mode: all rows move left once, on the first pixel
      if (!fill_full) begin
        for (int v = 0; v < 5; v++)
          for (int u = 0; u < 4; u++) gray_win[v*5+u] = gray_win[v*5+u+1];
      end
    end
    if (fill_full) begin
      needed = 25;
      if (fill_cnt >= 25) fill_cnt = 0;
      gray_win[fill_cnt] = gray;
    end else begin
      needed = 5;
      if (fill_cnt >= 5) fill_cnt = 0;
      gray_win[fill_cnt*5+4] = gray;
    end
    fill_cnt = fill_cnt + 5'd1;
    if (fill_cnt >= needed) begin
      fill_cnt = 0;
      done = 1'b1;
      filt = gauss_of_window();
    end
  endtask

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : int'($urandom_range(0, 10));
  endfunction

  // biased toward the channel extremes
  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Drive one pixel; called at a falling edge, returns at the falling edge
  // after its transfer. Predictor runs at the accepting rising edge.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic reload, input int gap,
                            input logic typed, input logic [7:0] typed_filt);
    bit         done;
    logic [7:0] filt;
    if (gap > 0) begin
      pix_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_bus.valid  <= 1'b1;
    pix_bus.red    <= r;
    pix_bus.green  <= g;
    pix_bus.blue   <= b;
    pix_bus.reload <= reload;
    do @(posedge clk); while (!pix_bus.ready);
    gauss_predict(r, g, b, reload, done, filt);
    if (done) filt_expected.push_back(typed ? typed_filt : filt);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Result side: random stalls per result, checked at the rising edge
  // ---------------------------------------------------------------------
  initial begin
    int stall;
    res_bus.ready <= 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = draw_wait(sink_calm);
      if (stall > 0) begin
        res_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_bus.ready <= 1'b1;
      do @(posedge clk); while (!res_bus.valid);
      @(negedge clk);
    end
  end

  // receiver alternates between stalling and calm stretches
  initial begin
    sink_calm = 1'b0;
    forever begin
      repeat (250) @(posedge clk);
      sink_calm = ($urandom_range(0, 3) == 0);
    end
  end

  logic [7:0] filt_want;
  always @(posedge clk) begin
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (filt_expected.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: filtered=%0d", res_bus.filtered);
      end else begin
        filt_want = filt_expected.pop_front();
        if (res_bus.filtered !== filt_want) begin
          fail_count++;
          if (fail_count <= 10)
            $display("filtered mismatch: expected %0d, got %0d", filt_want,
                     res_bus.filtered);
        end
      end
    end
  end

  // Watchdog: ends the run when neither side transfers for too long
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((pix_bus.valid && pix_bus.ready) || (res_bus.valid && res_bus.ready)) idle = 0;
      else idle++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    bit         src_calm;
    logic       reload;
    pix_row_t   row;
    rst_n          = 1'b0;
    pix_bus.valid  = 1'b0;
    pix_bus.red    = '0;
    pix_bus.green  = '0;
    pix_bus.blue   = '0;
    pix_bus.reload = 1'b0;
    src_calm       = 1'b0;
    for (int i = 0; i < 25; i++) gray_win[i] = '0;
    fill_cnt  = '0;
    fill_full = 1'b0;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    for (int i = 0; i < N_DIRECTED; i++) begin
      row = PIXEL_TABLE[i];
      send_pixel(row.r, row.g, row.b, row.reload, draw_wait(1'b0), row.typed, row.filt);
    end

    // random windows: new window mode drawn on each first pixel, reload noise
    // on the rest; source idling in blocks of 100 with calm stretches
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 100 == 0) src_calm = ($urandom_range(0, 2) == 0);
      // hold off until the pipeline is empty once, mid-run
      if (i == N_RANDOM / 2) begin
        pix_bus.valid <= 1'b0;
        do @(negedge clk); while (filt_expected.size() != 0);
      end
      if (fill_cnt == 0) reload = ($urandom_range(0, 9) < 3);
      else               reload = 1'($urandom_range(0, 1));
      send_pixel(rand_chan(), rand_chan(), rand_chan(), reload, draw_wait(src_calm),
                 1'b0, 8'd0);
    end
    pix_bus.valid <= 1'b0;

    while (filt_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_count == 0 && filt_expected.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
